// ===== hw/rtl/ray_box_nearest_hit_unit_macros.svh =====
// Assertion macros for the ray box nearest hit unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef RAY_BOX_NEAREST_HIT_UNIT_MACROS_SVH
`define RAY_BOX_NEAREST_HIT_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RBNH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBNH_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define RBNH_ASSERT(lbl, clk, rst_n, prop, msg)
`define RBNH_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/rbnh_pkg.sv =====
// Shared types and constants for the ray box nearest hit unit.
// No dependencies; imported by every module of the block except rbnh_ram.
`default_nettype none
package rbnh_pkg;
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_QUERY = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	localparam int IN_DATA_W  = 336;
	localparam int OUT_DATA_W = 72;
	localparam int ID_W       = 64;
	localparam int CELL_W     = 16;
	localparam int COORD_W    = 32;
	localparam int DEN_W      = 63;
	localparam int ENTRY_W    = ID_W + 3 * CELL_W;

	typedef struct packed {
		op_t                            op;
		logic [ID_W-1:0]                id;
		logic [2:0][CELL_W-1:0]         corner;
		logic [2:0][COORD_W-1:0]        origin;
		logic [2:0][COORD_W-1:0]        mag;
		logic [2:0]                     neg;
		logic [2:0][DEN_W-1:0]          den;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage
`default_nettype wire

// ===== hw/rtl/rbnh_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module rbnh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== hw/rtl/rbnh_front.sv =====
// Front end: accepts requests, unpacks them and scales the ray direction.
// Depends on rbnh_pkg.
`default_nettype none
module rbnh_front (
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rbnh_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic [1:0]                        s_tuser,
	input  rbnh_pkg::q_stat_t                 q_stat,
	output logic                              q_push,
	output rbnh_pkg::cmd_t                    q_cmd
);
	import rbnh_pkg::*;

	logic [30:0]  len;
	logic [31:0]  dir [3];

	always_comb begin
		len = s_tdata[334:304];
		q_cmd.op = op_t'(s_tuser);
		q_cmd.id = s_tdata[63:0];
		for (int k = 0; k < 3; k++) begin
			q_cmd.corner[k] = s_tdata[64 + 16*k +: 16];
			q_cmd.origin[k] = s_tdata[112 + 32*k +: 32];
			dir[k]          = s_tdata[208 + 32*k +: 32];
			q_cmd.neg[k]    = dir[k][31];
			q_cmd.mag[k]    = dir[k][31] ? (32'd0 - dir[k]) : dir[k];
			q_cmd.den[k]    = {31'd0, q_cmd.mag[k]} * {32'd0, len};
		end
	end

	assign s_tready = !q_stat.full;
	assign q_push   = s_tvalid && !q_stat.full;
endmodule
`default_nettype wire

// ===== hw/rtl/rbnh_fifo.sv =====
// Two entry request queue between the front end and the scan engine.
// Depends on rbnh_pkg.
`default_nettype none
module rbnh_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rbnh_pkg::cmd_t    din,
	input  logic              pop,
	output rbnh_pkg::cmd_t    head,
	output rbnh_pkg::q_stat_t stat
);
	import rbnh_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= din;
		end
	end

	assign head       = ent_q[rd_ptr_q];
	assign stat.full  = cnt_q == 2'd2;
	assign stat.empty = cnt_q == 2'd0;
endmodule
`default_nettype wire

// ===== hw/rtl/rbnh_back.sv =====
// Back end: executes adds and clears and runs the pipelined cell scan for queries.
// Depends on rbnh_pkg, rbnh_ram and the assertion macro header.
`default_nettype none
`include "ray_box_nearest_hit_unit_macros.svh"
module rbnh_back #(
	parameter int MAX_CELLS = 64,
	parameter int AW        = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
	parameter int CW        = $clog2(MAX_CELLS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rbnh_pkg::q_stat_t                 q_stat,
	input  rbnh_pkg::cmd_t                    q_head,
	output logic                              q_pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rbnh_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [0:0]                        m_tuser
);
	import rbnh_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} st_t;

	st_t                      st_q;
	logic [CW-1:0]            cnt_q;
	logic [CW-1:0]            idx_q;
	logic [2:0][COORD_W-1:0]  qo_q;
	logic [2:0][COORD_W-1:0]  qm_q;
	logic [2:0]               qneg_q;
	logic [2:0][DEN_W-1:0]    qden_q;

	logic                     room;
	logic                     we;
	logic [ENTRY_W-1:0]       rdata;

	logic                     v_s1;
	logic [AW-1:0]            slot_s1;

	logic signed [33:0]       m0_c [3];
	logic signed [33:0]       m1_c [3];
	logic signed [33:0]       dl_c [3];
	logic signed [33:0]       dh_c [3];
	logic [2:0]               zero_c;
	logic [2:0]               zok_c;

	logic                     v_s2;
	logic [AW-1:0]            slot_s2;
	logic [ID_W-1:0]          id_s2;
	logic signed [33:0]       m0_s2 [3];
	logic signed [33:0]       m1_s2 [3];
	logic signed [33:0]       dl_s2 [3];
	logic [2:0]               zero_s2;
	logic                     ok_s2;

	logic signed [66:0]       p_c [3][3];
	logic signed [66:0]       r_c [3][3];
	logic signed [67:0]       sq_c [3];

	logic                     v_s3;
	logic [AW-1:0]            slot_s3;
	logic [ID_W-1:0]          id_s3;
	logic signed [66:0]       p_s3 [3][3];
	logic signed [66:0]       r_s3 [3][3];
	logic [63:0]              sq_s3 [3];
	logic [2:0]               zero_s3;
	logic                     ok_s3;

	logic                     cross_c;

	logic                     v_s4;
	logic [AW-1:0]            slot_s4;
	logic [ID_W-1:0]          id_s4;
	logic                     hit_s4;
	logic [65:0]              sum_s4;

	logic                     found_q;
	logic [AW-1:0]            best_slot_q;
	logic [ID_W-1:0]          best_id_q;
	logic [65:0]              best_d_q;

	logic                     out_valid_q;
	logic                     out_status_q;
	logic                     out_hit_q;
	logic [5:0]               out_slot_q;
	logic [ID_W-1:0]          out_id_q;

	logic                     pipe_busy;

	assign room      = cnt_q < CW'(MAX_CELLS);
	assign q_pop     = (st_q == ST_IDLE) && !q_stat.empty && !out_valid_q;
	assign we        = q_pop && (q_head.op == OP_ADD) && room;
	assign pipe_busy = v_s1 || v_s2 || v_s3 || v_s4;

	rbnh_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(cnt_q[AW-1:0]),
		.wdata({q_head.id, q_head.corner}),
		.raddr(idx_q[AW-1:0]),
		.rdata(rdata)
	);

	// slab bounds, reduced by the common 2^16 factor
	always_comb begin
		logic signed [33:0] lo_e;
		logic signed [33:0] hi_e;
		logic signed [33:0] o_e;
		logic [15:0]        c;
		logic [16:0]        c1;
		for (int k = 0; k < 3; k++) begin
			c         = rdata[16*k +: 16];
			c1        = {c[15], c} + 17'd1;
			lo_e      = {{2{c[15]}}, c, 16'h0};
			hi_e      = {c1[16], c1, 16'h0};
			o_e       = {{2{qo_q[k][31]}}, qo_q[k]};
			dl_c[k]   = lo_e - o_e;
			dh_c[k]   = hi_e - o_e;
			m0_c[k]   = qneg_q[k] ? -dh_c[k] : dl_c[k];
			m1_c[k]   = qneg_q[k] ? -dl_c[k] : dh_c[k];
			zero_c[k] = qden_q[k] == '0;
			if (zero_c[k]) begin
				zok_c[k] = (dl_c[k] <= 0) && (dh_c[k] >= 0);
			end else begin
				zok_c[k] = (m0_c[k][33] ||
					({15'd0, m0_c[k][32:0], 16'h0} <= {1'b0, qden_q[k]})) && !m1_c[k][33];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = dl_s2[i] * dl_s2[i];
			for (int j = 0; j < 3; j++) begin
				if (i != j) begin
					p_c[i][j] = m0_s2[i] * $signed({1'b0, qm_q[j]});
					r_c[i][j] = m1_s2[j] * $signed({1'b0, qm_q[i]});
				end else begin
					p_c[i][j] = '0;
					r_c[i][j] = '0;
				end
			end
		end
	end

	always_comb begin
		cross_c = 1'b1;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (i != j && !zero_s3[i] && !zero_s3[j] && (p_s3[i][j] > r_s3[i][j])) begin
					cross_c = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q[AW-1:0];
		slot_s2 <= slot_s1;
		id_s2   <= rdata[ENTRY_W-1:3*CELL_W];
		ok_s2   <= &zok_c;
		zero_s2 <= zero_c;
		for (int k = 0; k < 3; k++) begin
			m0_s2[k] <= m0_c[k];
			m1_s2[k] <= m1_c[k];
			dl_s2[k] <= dl_c[k];
		end
		slot_s3 <= slot_s2;
		id_s3   <= id_s2;
		ok_s3   <= ok_s2;
		zero_s3 <= zero_s2;
		for (int i = 0; i < 3; i++) begin
			sq_s3[i] <= sq_c[i][63:0];
			for (int j = 0; j < 3; j++) begin
				p_s3[i][j] <= p_c[i][j];
				r_s3[i][j] <= r_c[i][j];
			end
		end
		slot_s4 <= slot_s3;
		id_s4   <= id_s3;
		hit_s4  <= ok_s3 && cross_c;
		sum_s4  <= {2'b0, sq_s3[0]} + {2'b0, sq_s3[1]} + {2'b0, sq_s3[2]};
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_head.op == OP_QUERY) begin
			qo_q   <= q_head.origin;
			qm_q   <= q_head.mag;
			qneg_q <= q_head.neg;
			qden_q <= q_head.den;
		end
		if (v_s4 && hit_s4 && (!found_q || sum_s4 < best_d_q)) begin
			best_slot_q <= slot_s4;
			best_id_q   <= id_s4;
			best_d_q    <= sum_s4;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			cnt_q        <= '0;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			found_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= 1'b0;
			out_hit_q    <= 1'b0;
			out_slot_q   <= '0;
			out_id_q     <= '0;
		end else begin
			v_s1 <= st_q == ST_SCAN;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4 && hit_s4) begin
				found_q <= 1'b1;
			end
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						out_status_q <= 1'b0;
						out_hit_q    <= 1'b0;
						out_slot_q   <= '0;
						out_id_q     <= '0;
						case (q_head.op)
							OP_ADD: begin
								out_valid_q <= 1'b1;
								if (room) begin
									cnt_q <= cnt_q + CW'(1);
								end else begin
									out_status_q <= 1'b1;
								end
							end
							OP_CLEAR: begin
								out_valid_q <= 1'b1;
								cnt_q       <= '0;
							end
							OP_QUERY: begin
								found_q <= 1'b0;
								idx_q   <= '0;
								st_q    <= (cnt_q == '0) ? ST_DRAIN : ST_SCAN;
							end
							default: begin
								out_valid_q <= 1'b1;
							end
						endcase
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + CW'(1);
					if (idx_q == cnt_q - CW'(1)) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						out_valid_q  <= 1'b1;
						out_status_q <= 1'b0;
						out_hit_q    <= found_q;
						out_slot_q   <= found_q ? 6'(best_slot_q) : 6'd0;
						out_id_q     <= found_q ? best_id_q : '0;
						st_q         <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_id_q, out_slot_q, out_hit_q};
	assign m_tuser  = out_status_q;

	`RBNH_ASSERT_NEVER(a_cnt_max, clk, arst_n, cnt_q > CW'(MAX_CELLS), "entry count above table size")
	`RBNH_ASSERT(a_scan_range, clk, arst_n, (st_q == ST_SCAN) |-> (idx_q < cnt_q), "scan index past fill")
	`RBNH_ASSERT(a_drain_quiet, clk, arst_n, (st_q == ST_DRAIN) |=> !v_s1, "read issued while draining")
	`RBNH_ASSERT(a_hit_status, clk, arst_n, (out_valid_q && out_hit_q) |-> !out_status_q, "hit with full status")
endmodule
`default_nettype wire

// ===== hw/rtl/ray_box_nearest_hit_unit.sv =====
// Nearest unit cell hit by a ray segment, over a table of up to MAX_CELLS cells.
// Add, clear and unused requests: result registered as the request leaves the queue.
// Query: result valid after the scan drains (no scan on an empty table), reading
// one stored cell per cycle through the table RAM and a pipelined slab test.
// One request in the back end at a time; the next leaves the two entry queue the cycle
// after the result is taken. Reset (arst_n low) empties the table and all control state.
`default_nettype none
module ray_box_nearest_hit_unit #(
	parameter int MAX_CELLS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// entity_id_in, cell_x, cell_y, cell_z, origin_x, origin_y, origin_z,
	// dir_x, dir_y, dir_z, ray_length, one pad bit
	input  logic [rbnh_pkg::IN_DATA_W-1:0]    s_tdata,
	// operation
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit, hit_slot, hit_id, one pad bit
	output logic [rbnh_pkg::OUT_DATA_W-1:0]   m_tdata,
	// status
	output logic [0:0]                        m_tuser
);
	import rbnh_pkg::*;

	q_stat_t q_stat;
	logic    q_push;
	logic    q_pop;
	cmd_t    q_cmd;
	cmd_t    q_head;

	rbnh_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_stat  (q_stat),
		.q_push  (q_push),
		.q_cmd   (q_cmd)
	);

	rbnh_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_cmd),
		.pop   (q_pop),
		.head  (q_head),
		.stat  (q_stat)
	);

	rbnh_back #(
		.MAX_CELLS(MAX_CELLS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);
endmodule
`default_nettype wire

// ===== tb/sv/ray_box_nearest_hit_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the ray box nearest hit unit: predicts each accepted request's result
// from its own copy of the cell table and compares it with the result stream.
// Depends on rbnh_pkg for the operation codes and bus widths.
module ray_box_nearest_hit_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [rbnh_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [1:0]                       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [rbnh_pkg::OUT_DATA_W-1:0]  m_tdata,
	input  logic [0:0]                       m_tuser,
	output int                               pending,
	output int                               fail_count,
	output int                               hit_count,
	output int                               refused_count
);
	import rbnh_pkg::*;

	localparam int TABLE_DEPTH = 64;

	typedef struct packed {
		logic        status;
		logic        hit;
		logic [5:0]  slot;
		logic [63:0] id;
	} hit_result_t;

	hit_result_t expected_hits[$];
	int          cell_corner[TABLE_DEPTH][3];
	logic [63:0] cell_id[TABLE_DEPTH];
	int          cell_count;

	function automatic bit ratio_below(longint a, longint b, longint c, longint d);
		logic signed [127:0] wa, wb, wc, wd;
		wa = a;
		wb = b;
		wc = c;
		wd = d;
		return (wa * wd) < (wc * wb);
	endfunction

	// narrow the t interval by one axis; 0 for a zero direction outside the slab
	function automatic bit clip_axis(input longint o, input longint c, input longint dd,
			inout longint ln, inout longint ld, inout longint un, inout longint ud);
		longint lo, hi, n0, n1, den, t;
		lo = c * 65536;
		hi = (c + 1) * 65536;
		if (dd == 0)
			return (lo <= o) && (o <= hi);
		n0 = (lo - o) * 65536;
		n1 = (hi - o) * 65536;
		den = dd;
		if (dd < 0) begin
			t = n0;
			n0 = -n1;
			n1 = -t;
			den = -dd;
		end
		if (ratio_below(ln, ld, n0, den)) begin
			ln = n0;
			ld = den;
		end
		if (ratio_below(n1, den, un, ud)) begin
			un = n1;
			ud = den;
		end
		return 1'b1;
	endfunction

	function automatic hit_result_t nearest_hit(logic [1:0] op, logic [IN_DATA_W-1:0] d);
		hit_result_t r;
		longint org[3], dvec[3], ln, ld, un, ud, diff, len;
		logic [127:0] sq_dist, best_dist;
		logic [63:0] m;
		bit ok, found;
		int best;
		r = '0;
		case (op_t'(op))
		OP_ADD: begin
			if (cell_count >= TABLE_DEPTH) begin
				r.status = 1'b1;
			end else begin
				cell_id[cell_count] = d[63:0];
				for (int k = 0; k < 3; k++)
					cell_corner[cell_count][k] = $signed(d[64 + 16*k +: 16]);
				cell_count++;
			end
		end
		OP_CLEAR: cell_count = 0;
		OP_QUERY: begin
			len = longint'(d[334:304]);
			for (int k = 0; k < 3; k++) begin
				org[k] = longint'($signed(d[112 + 32*k +: 32]));
				dvec[k] = longint'($signed(d[208 + 32*k +: 32])) * len;
			end
			found = 0;
			best = 0;
			best_dist = '0;
			for (int i = 0; i < cell_count; i++) begin
				ln = 0; ld = 1; un = 1; ud = 1;
				ok = 1;
				for (int k = 0; k < 3 && ok; k++)
					ok = clip_axis(org[k], cell_corner[i][k], dvec[k], ln, ld, un, ud);
				if (!ok || ratio_below(un, ud, ln, ld))
					continue;
				sq_dist = '0;
				for (int k = 0; k < 3; k++) begin
					diff = longint'(cell_corner[i][k]) * 65536 - org[k];
					m = diff < 0 ? -diff : diff;
					sq_dist += {64'd0, m} * {64'd0, m};
				end
				if (!found || sq_dist < best_dist) begin
					found = 1;
					best_dist = sq_dist;
					best = i;
				end
			end
			if (found) begin
				r.hit = 1'b1;
				r.slot = best[5:0];
				r.id = cell_id[best];
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	assign pending = expected_hits.size();

	always @(posedge clk or negedge arst_n) begin
		hit_result_t got, want;
		if (!arst_n) begin
			expected_hits.delete();
			cell_count = 0;
			fail_count <= 0;
			hit_count <= 0;
			refused_count <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_hits.insert(expected_hits.size(), nearest_hit(s_tuser, s_tdata));
			if (m_tvalid && m_tready) begin
				got.status = m_tuser[0];
				got.hit = m_tdata[0];
				got.slot = m_tdata[6:1];
				got.id = m_tdata[70:7];
				if (expected_hits.size() == 0) begin
					$error("result with nothing expected: %p", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_hits.pop_front();
					if (got.hit) hit_count <= hit_count + 1;
					if (got.status) refused_count <= refused_count + 1;
					if (got != want) begin
						fail_count <= fail_count + 1;
						if (got.status != want.status)
							$error("status expected %0d got %0d", want.status, got.status);
						if (got.hit != want.hit)
							$error("hit expected %0d got %0d", want.hit, got.hit);
						if (got.slot != want.slot)
							$error("hit_slot expected %0d got %0d", want.slot, got.slot);
						if (got.id != want.id)
							$error("hit_id expected %h got %h", want.id, got.id);
					end
				end
			end
		end
	end
endmodule

// ===== tb/sv/tb_ray_box_nearest_hit_unit.sv =====
`timescale 1ns / 100ps
// Top of the ray box nearest hit unit testbench: clock, reset, request stimulus and verdict.
// Depends on rbnh_pkg, ray_box_nearest_hit_unit and ray_box_nearest_hit_checker.
module tb_ray_box_nearest_hit_unit;
	import rbnh_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam int LONG_HOLD    = 500;

	logic                   clk = 0;
	logic                   arst_n = 0;
	logic                   s_tvalid = 0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [1:0]             s_tuser = OP_NONE;
	logic                   m_tvalid;
	logic                   m_tready = 0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic [0:0]             m_tuser;
	int                     pending, fail_count, hit_count, refused_count;
	int                     cycle_count = 0;
	int                     burst_left = 0;
	bit                     hold_go = 0;
	int                     sent = 0;

	ray_box_nearest_hit_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	ray_box_nearest_hit_checker chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.pending(pending), .fail_count(fail_count), .hit_count(hit_count),
		.refused_count(refused_count)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stall modes, plus one long hold-off
	int stall_mode = 0, mode_left = 0, hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_done = 1;
			hold_left = LONG_HOLD;
		end
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(5, 200);
		end
		mode_left--;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 1) == 0);
			2: m_tready <= ($urandom_range(0, 7) == 0);
			default: m_tready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic logic [IN_DATA_W-1:0] pack_request(logic [63:0] id,
			logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
			logic [31:0] dx, logic [31:0] dy, logic [31:0] dz, logic [31:0] len);
		return {1'b0, len[30:0], dz, dy, dx, oz, oy, ox, cz[15:0], cy[15:0], cx[15:0], id};
	endfunction

	task automatic send(op_t op, logic [IN_DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	function automatic logic [31:0] near_coord();
		return {16'($urandom_range(0, 12) - 6), 16'd0} + (($urandom_range(0, 3) == 0) ? 32'd0
			: 32'($urandom_range(0, 65535)));
	endfunction

	function automatic logic [31:0] near_dir();
		if ($urandom_range(0, 4) == 0)
			return 32'd0;
		return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
	endfunction

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] HALF = 32'h0000_8000;

	initial begin
		logic [63:0] rid;
		logic [351:0] noise;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_QUERY, pack_request(0, 0, 0, 0, HALF, HALF, HALF, ONE, 0, 0, ONE));
		send(OP_NONE, '1);
		send(OP_ADD, pack_request(64'h1111, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(OP_ADD, pack_request(64'h2222, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(OP_ADD, pack_request('1, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0, 0, 0));
		send(OP_ADD, pack_request(0, 16'h7fff, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 0, 0));
		// along +x from the left, both cells lie on the segment
		send(OP_QUERY, pack_request(0, 0, 0, 0, -ONE, HALF, HALF, ONE, 0, 0, 8 * ONE));
		// along -x from the right
		send(OP_QUERY, pack_request(0, 0, 0, 0, 4 * ONE, HALF, HALF, -ONE, 0, 0, 8 * ONE));
		// zero direction inside and on a face, and zero x direction outside
		send(OP_QUERY, pack_request(0, 0, 0, 0, HALF, HALF, HALF, 0, 0, 0, 0));
		send(OP_QUERY, pack_request(0, 0, 0, 0, ONE, HALF, HALF, 0, 0, 0, ONE));
		send(OP_QUERY, pack_request(0, 0, 0, 0, ONE + HALF, HALF, HALF, 0, ONE, 0, ONE));
		// segment too short to reach
		send(OP_QUERY, pack_request(0, 0, 0, 0, -5 * ONE, HALF, HALF, ONE, 0, 0, ONE));
		// touching at the end of the segment
		send(OP_QUERY, pack_request(0, 0, 0, 0, -ONE, HALF, HALF, ONE, 0, 0, ONE));
		// corners of the field ranges
		send(OP_QUERY, pack_request(0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send(OP_QUERY, pack_request(0, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
		// duplicate cell: the earlier slot wins the tie
		send(OP_ADD, pack_request(64'h3333, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send(OP_QUERY, pack_request(0, 0, 0, 0, HALF, HALF, -ONE, 0, 0, ONE, 4 * ONE));
		send(OP_CLEAR, '0);
		send(OP_QUERY, pack_request(0, 0, 0, 0, HALF, HALF, HALF, 0, 0, 0, 0));

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3)
				hold_go = 1;
			if (n == RANDOM_ITEMS / 2 || n == (2 * RANDOM_ITEMS) / 3) begin
				s_tvalid <= 1'b0;
				burst_left = 0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			rid = {$urandom(), $urandom()};
			if (pick < 35)
				send(OP_ADD, pack_request(rid, $urandom_range(0, 12) - 6,
					$urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
					0, 0, 0, 0, 0, 0, 0));
			else if (pick < 90)
				send(OP_QUERY, pack_request(0, 0, 0, 0, near_coord(), near_coord(),
					near_coord(), near_dir(), near_dir(), near_dir(),
					$urandom_range(0, 3 * ONE)));
			else if (pick < 93)
				send(OP_CLEAR, pack_request(rid, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
			else if (pick < 94)
				send(OP_NONE, pack_request(rid, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
			else begin
				noise = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
				send(op_t'($urandom_range(0, 3)), {1'b0, noise[IN_DATA_W-2:0]});
			end
		end
		s_tvalid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("sent %0d requests: %0d query hits, %0d adds refused on a full table",
			sent, hit_count, refused_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
